/* sv/pli_pkg.sv */
// Shared types for the piecewise linear interpolator.
// Holds the query token that walks the cell row and the state encodings.
// No dependencies.
package pli_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS      = 16;

  // Query token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              oor;
    logic              found;
    logic signed [31:0] q;
    logic signed [31:0] xk;
    logic signed [31:0] xk1;
    logic signed [31:0] yk;
    logic signed [31:0] yk1;
  } pli_token_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CALC
  } pli_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_MUL,
    DV_SUM
  } pli_div_t;

endpackage

/* sv/pli_cell.sv */
// One breakpoint cell: stores one (x, y) pair and passes the query token on.
// Depends on pli_pkg.
module pli_cell import pli_pkg::*; #(
  parameter int IDX  = 0,
  parameter int IDXW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [IDXW-1:0]    last_idx,
  input  logic               wr_en,
  input  logic [5:0]         wr_idx,
  input  logic signed [31:0] wr_x,
  input  logic signed [31:0] wr_y,
  input  logic signed [31:0] prev_x,
  input  logic signed [31:0] prev_y,
  input  pli_token_t         tok_in,
  output pli_token_t         tok_out,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out
);

  localparam logic [IDXW-1:0] MY = IDXW'(IDX);

  pli_token_t tok_next;
  logic       in_use;
  logic       is_last;

  // Store the breakpoint on a load aimed at this slot
  always_ff @(posedge clk) begin
    if (wr_en && (int'(wr_idx) == IDX)) begin
      x_out <= wr_x;
      y_out <= wr_y;
    end
  end

  // Range check and first-hit capture
  always_comb begin
    in_use   = (MY <= last_idx);
    is_last  = (MY == last_idx);
    tok_next = tok_in;
    if (IDX == 0) begin
      if (tok_in.q < x_out) tok_next.oor = 1'b1;
    end else if (in_use) begin
      if (is_last && (tok_in.q > x_out)) tok_next.oor = 1'b1;
      if (!tok_in.found && ((x_out >= tok_in.q) || is_last)) begin
        tok_next.found = 1'b1;
        tok_next.xk    = prev_x;
        tok_next.xk1   = x_out;
        tok_next.yk    = prev_y;
        tok_next.yk1   = y_out;
      end
    end
  end

  // Advance the token one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* sv/pli_interp.sv */
// Interpolation unit: bit-serial fraction divide, one multiply, final add;
// out-of-range queries and zero-width segments bypass them. Depends on pli_pkg.
module pli_interp import pli_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pli_token_t         tok,
  output logic               done,
  output logic signed [31:0] result,
  output logic               status
);

  pli_div_t state;
  logic [4:0]          cnt;
  logic [32:0]         rem;
  logic [32:0]         aden;
  logic [16:0]         tq;
  logic signed [31:0]  yk;
  logic signed [32:0]  dy;
  logic signed [50:0]  prod;

  logic signed [32:0]  num;
  logic signed [32:0]  den;
  logic [32:0]         anum;
  logic [32:0]         aden_c;
  logic [33:0]         rem2;
  logic                take;
  logic signed [50:0]  adj;

  // Operand preparation
  always_comb begin
    num    = 33'(tok.q) - 33'(tok.xk);
    den    = 33'(tok.xk1) - 33'(tok.xk);
    anum   = num[32] ? 33'(-num) : 33'(num);
    aden_c = den[32] ? 33'(-den) : 33'(den);
    rem2   = {rem, 1'b0};
    take   = (rem2 >= {1'b0, aden});
    adj    = prod + (prod[50] ? 51'sd65535 : 51'sd0);
  end

  // Sequence divide, multiply and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (start) begin
            yk     <= tok.yk;
            dy     <= 33'(tok.yk1) - 33'(tok.yk);
            aden   <= aden_c;
            rem    <= anum;
            status <= tok.oor;
            if (tok.oor) begin
              result <= '0;
              done   <= 1'b1;
            end else if (den == '0) begin
              result <= tok.yk;
              done   <= 1'b1;
            end else if (num[32] ^ den[32]) begin
              tq    <= '0;
              state <= DV_MUL;
            end else if (anum >= aden_c) begin
              tq    <= 17'(1 << FRAC_BITS);
              state <= DV_MUL;
            end else begin
              tq    <= '0;
              cnt   <= 5'(FRAC_BITS);
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          rem <= take ? 33'(rem2 - {1'b0, aden}) : rem2[32:0];
          tq  <= {tq[15:0], take};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) state <= DV_MUL;
        end
        DV_MUL: begin
          prod  <= $signed({{34{1'b0}}, tq}) * $signed({{18{dy[32]}}, dy});
          state <= DV_SUM;
        end
        DV_SUM: begin
          result <= yk + adj[47:16];
          done   <= 1'b1;
          state  <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

/* sv/piecewise_linear_interp.sv */
// Top level of the piecewise linear interpolator: cell row, control, output.
// Depends on pli_pkg, pli_cell and pli_interp.
//
//   channel  | handshake          | payload
//   s_*      | s_tvalid/s_tready  | s_tuser operation, s_tdata index/x/y
//   m_*      | m_tvalid/m_tready  | m_tdata result_value, m_tuser status
//   cfg_*    | cfg_we             | cfg_data points_in_use
//
// A load is answered in the cycle after it is taken. A query walks the row of
// MAX_POINTS cells, one cell a cycle, then the interpolation unit forms the result.
// One item is in flight at a time; input is taken while the output is free.
// Reset is synchronous; table contents are not cleared.
module piecewise_linear_interp import pli_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // point_index[5:0], x_value[37:6], y_value[69:38]
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value[31:0]
  output logic        m_tuser,   // status
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);

  localparam int IDXW = $clog2(MAX_POINTS);

  pli_state_t state;
  pli_state_t state_next;
  logic [6:0]         points_in_use;
  logic [IDXW-1:0]    last_idx;
  logic               s_xfer;
  logic               load_xfer;
  logic               query_xfer;
  pli_token_t         tok_launch;
  pli_token_t         tok [1:MAX_POINTS];
  logic signed [31:0] x_row [MAX_POINTS];
  logic signed [31:0] y_row [MAX_POINTS];
  logic               calc_start;
  logic               calc_done;
  logic signed [31:0] calc_result;
  logic               calc_status;
  int                 n_act;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= 7'd2;
    end else if (cfg_we) begin
      points_in_use <= cfg_data;
    end
  end

  // Clamp the point count and form the last slot index
  always_comb begin
    n_act = int'(points_in_use);
    if (n_act < 2) n_act = 2;
    if (n_act > MAX_POINTS) n_act = MAX_POINTS;
    last_idx = IDXW'(n_act - 1);
  end

  assign s_xfer     = s_tvalid && s_tready;
  assign load_xfer  = s_xfer && !s_tuser;
  assign query_xfer = s_xfer && s_tuser;

  // Launch token into the first cell
  always_comb begin
    tok_launch       = '0;
    tok_launch.valid = query_xfer;
    tok_launch.q     = s_tdata[37:6];
  end

  // Row of breakpoint cells
  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    if (g == 0) begin : g_first
      pli_cell #(.IDX(g), .IDXW(IDXW)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .last_idx(last_idx),
        .wr_en   (load_xfer),
        .wr_idx  (s_tdata[5:0]),
        .wr_x    (s_tdata[37:6]),
        .wr_y    (s_tdata[69:38]),
        .prev_x  (x_row[g]),
        .prev_y  (y_row[g]),
        .tok_in  (tok_launch),
        .tok_out (tok[g+1]),
        .x_out   (x_row[g]),
        .y_out   (y_row[g])
      );
    end else begin : g_rest
      pli_cell #(.IDX(g), .IDXW(IDXW)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .last_idx(last_idx),
        .wr_en   (load_xfer),
        .wr_idx  (s_tdata[5:0]),
        .wr_x    (s_tdata[37:6]),
        .wr_y    (s_tdata[69:38]),
        .prev_x  (x_row[g-1]),
        .prev_y  (y_row[g-1]),
        .tok_in  (tok[g]),
        .tok_out (tok[g+1]),
        .x_out   (x_row[g]),
        .y_out   (y_row[g])
      );
    end
  end

  assign calc_start = (state == ST_WALK) && tok[MAX_POINTS].valid;

  pli_interp u_interp (
    .clk   (clk),
    .rst   (rst),
    .start (calc_start),
    .tok   (tok[MAX_POINTS]),
    .done  (calc_done),
    .result(calc_result),
    .status(calc_status)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (query_xfer) state_next = ST_WALK;
      ST_WALK: if (tok[MAX_POINTS].valid) state_next = ST_CALC;
      ST_CALC: if (calc_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Input handshake
  always_comb begin
    s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_xfer || calc_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_xfer) begin
      m_tdata <= '0;
      m_tuser <= 1'b0;
    end else if (calc_done) begin
      m_tdata <= calc_result;
      m_tuser <= calc_status;
    end
  end

endmodule

/* sv/pli_checker.sv */
// Port-level checks for piecewise_linear_interp, bound to the top level.
// Depends on nothing but the top level's ports.
module pli_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [71:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        cfg_we,
  input logic [6:0]  cfg_data
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A query blocks the input on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken during a query");

  // A load returns zero with ok status
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> m_tvalid && (m_tdata == '0) && !m_tuser)
    else $error("load result wrong");

  // Out of range reads zero
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0))
    else $error("out of range result not zero");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind piecewise_linear_interp pli_checker u_pli_checker (.*);
